FILE: hw/rtl/eedp_pkg.sv
// Types, phase codes and field kind codes shared by the extended event descriptor parser.
`timescale 1ns / 1ps
`default_nettype none

package eedp_pkg;

  localparam int PHASE_W = 4;
  localparam int KIND_W  = 4;

  // Parse phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_LENGTH    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_NUMBERS   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_LANG      = 4'd3;
  localparam logic [PHASE_W-1:0] PH_ITEMS_LEN = 4'd4;
  localparam logic [PHASE_W-1:0] PH_DESC_LEN  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_DESC_CHAR = 4'd6;
  localparam logic [PHASE_W-1:0] PH_ITEM_LEN  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_ITEM_CHAR = 4'd8;
  localparam logic [PHASE_W-1:0] PH_TEXT_LEN  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_TEXT_CHAR = 4'd10;

  // Field kinds reported with each byte
  localparam logic [KIND_W-1:0] KIND_IGNORED   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_TAG       = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LENGTH    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NUMBERS   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LANGUAGE  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ITEMS_LEN = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DESC_LEN  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DESC_CHAR = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ITEM_LEN  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_ITEM_CHAR = 4'd9;
  localparam logic [KIND_W-1:0] KIND_TEXT_LEN  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_TEXT_CHAR = 4'd11;

  localparam logic [7:0] LANG_BYTES = 8'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] field_kind;
    logic [7:0]        field_byte;
    logic [3:0]        number_high;
    logic [3:0]        number_low;
    logic [7:0]        item_index;
    logic              last_of_descriptor;
    logic              overrun_error;
  } out_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [7:0]         field_remaining;
    logic [7:0]         items_remaining;
    logic [7:0]         current_item;
    logic               overrun_seen;
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/eedp_step.sv
// Per-byte parse step: next parser state and the result for one request.
`timescale 1ns / 1ps
`default_nettype none

module eedp_step (
  input  eedp_pkg::state_t state,
  input  eedp_pkg::in_t    req,
  output eedp_pkg::state_t state_next,
  output eedp_pkg::out_t   res
);
  import eedp_pkg::*;

  logic [7:0]        b;
  logic [7:0]        items_dec;
  logic [7:0]        field_dec;
  logic [KIND_W-1:0] kind;
  logic              last;
  logic              use_index;
  logic              nibbles;

  assign b         = req.data_byte;
  assign items_dec = state.items_remaining - 8'd1;
  assign field_dec = state.field_remaining - 8'd1;

  always_comb begin
    state_next = state;
    kind       = KIND_IGNORED;
    last       = 1'b0;
    use_index  = 1'b0;
    nibbles    = 1'b0;
    if (req.start_flag) begin
      kind                       = KIND_TAG;
      state_next.phase           = PH_LENGTH;
      state_next.field_remaining = '0;
      state_next.items_remaining = '0;
      state_next.current_item    = '0;
      state_next.overrun_seen    = 1'b0;
    end else begin
      unique case (state.phase)
        PH_LENGTH: begin
          kind             = KIND_LENGTH;
          state_next.phase = PH_NUMBERS;
        end
        PH_NUMBERS: begin
          kind                       = KIND_NUMBERS;
          nibbles                    = 1'b1;
          state_next.field_remaining = LANG_BYTES;
          state_next.phase           = PH_LANG;
        end
        PH_LANG: begin
          kind                       = KIND_LANGUAGE;
          state_next.field_remaining = field_dec;
          if (field_dec == 8'd0) state_next.phase = PH_ITEMS_LEN;
        end
        PH_ITEMS_LEN: begin
          kind                       = KIND_ITEMS_LEN;
          state_next.items_remaining = b;
          state_next.phase           = (b == 8'd0) ? PH_TEXT_LEN : PH_DESC_LEN;
        end
        PH_DESC_LEN: begin
          kind                       = KIND_DESC_LEN;
          use_index                  = 1'b1;
          state_next.items_remaining = items_dec;
          state_next.field_remaining = b;
          if (items_dec == 8'd0) begin
            state_next.overrun_seen = 1'b1;
            state_next.phase        = PH_TEXT_LEN;
          end else begin
            state_next.phase = (b == 8'd0) ? PH_ITEM_LEN : PH_DESC_CHAR;
          end
        end
        PH_DESC_CHAR: begin
          kind                       = KIND_DESC_CHAR;
          use_index                  = 1'b1;
          state_next.items_remaining = items_dec;
          state_next.field_remaining = field_dec;
          if (items_dec == 8'd0) begin
            state_next.overrun_seen = 1'b1;
            state_next.phase        = PH_TEXT_LEN;
          end else if (field_dec == 8'd0) begin
            state_next.phase = PH_ITEM_LEN;
          end
        end
        PH_ITEM_LEN: begin
          kind                       = KIND_ITEM_LEN;
          use_index                  = 1'b1;
          state_next.items_remaining = items_dec;
          state_next.field_remaining = b;
          // An empty item text closes the item even on the last byte of the area.
          if (b == 8'd0) begin
            state_next.current_item = state.current_item + 8'd1;
            state_next.phase        = (items_dec == 8'd0) ? PH_TEXT_LEN : PH_DESC_LEN;
          end else if (items_dec == 8'd0) begin
            state_next.overrun_seen = 1'b1;
            state_next.phase        = PH_TEXT_LEN;
          end else begin
            state_next.phase = PH_ITEM_CHAR;
          end
        end
        PH_ITEM_CHAR: begin
          kind                       = KIND_ITEM_CHAR;
          use_index                  = 1'b1;
          state_next.items_remaining = items_dec;
          state_next.field_remaining = field_dec;
          if (field_dec == 8'd0) begin
            state_next.current_item = state.current_item + 8'd1;
            state_next.phase        = (items_dec == 8'd0) ? PH_TEXT_LEN : PH_DESC_LEN;
          end else if (items_dec == 8'd0) begin
            state_next.overrun_seen = 1'b1;
            state_next.phase        = PH_TEXT_LEN;
          end
        end
        PH_TEXT_LEN: begin
          kind                       = KIND_TEXT_LEN;
          state_next.field_remaining = b;
          if (b == 8'd0) begin
            last             = 1'b1;
            state_next.phase = PH_IDLE;
          end else begin
            state_next.phase = PH_TEXT_CHAR;
          end
        end
        PH_TEXT_CHAR: begin
          kind                       = KIND_TEXT_CHAR;
          state_next.field_remaining = field_dec;
          if (field_dec == 8'd0) begin
            last             = 1'b1;
            state_next.phase = PH_IDLE;
          end
        end
        default: begin
          // Idle and unused codes: the byte is ignored and only the phase settles.
          state_next.phase = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.field_kind         = kind;
    res.field_byte         = b;
    res.number_high        = nibbles ? b[7:4] : 4'd0;
    res.number_low         = nibbles ? b[3:0] : 4'd0;
    res.item_index         = use_index ? state.current_item : 8'd0;
    res.last_of_descriptor = last;
    res.overrun_error      = (kind != KIND_IGNORED) && state_next.overrun_seen;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/extended_event_descriptor_parser.sv
// Top level of the extended event descriptor parser: request, parser state and result registers.
//
//   channel  direction  handshake              payload
//   src      in         src_valid/src_ready    src_data (eedp_pkg::in_t)
//   dst      out        dst_valid/dst_ready    dst_data (eedp_pkg::out_t)
//
// One request is taken in every cycle while src_ready is high. An accepted request is first
// stored in the request register, and its result is then loaded from there into the result
// register, which raises dst_valid. Reset clears the parser state to idle and empties both registers.
// When the result register is full and not taken, the request register holds its request;
// src_ready falls only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module extended_event_descriptor_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           src_valid,
  output logic                src_ready,
  input  eedp_pkg::in_t       src_data,
  output logic                dst_valid,
  input  wire logic           dst_ready,
  output eedp_pkg::out_t      dst_data
);
  import eedp_pkg::*;

  logic   hold_valid;
  in_t    hold;
  logic   advance;
  state_t state;
  state_t state_next;
  out_t   step_res;

  assign advance   = hold_valid && (!dst_valid || dst_ready);
  assign src_ready = !hold_valid || advance;

  eedp_step u_step (
    .state      (state),
    .req        (hold),
    .state_next (state_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src_ready) begin
      hold_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      hold <= src_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= PH_IDLE;
      state.field_remaining <= '0;
      state.items_remaining <= '0;
      state.current_item    <= '0;
      state.overrun_seen    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dst_data <= step_res;
    end
  end

`ifndef SYNTHESIS
  // Back-pressure reaches the source only when both registers are occupied.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> (hold_valid && dst_valid && !dst_ready))
    else $error("src_ready low while a register is free");

  // The end of a descriptor returns the parser to idle.
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && step_res.last_of_descriptor) |=> (state.phase == PH_IDLE))
    else $error("parser not idle after last byte of descriptor");

  // Only text length or text bytes can close a descriptor.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_data.last_of_descriptor) |->
      (dst_data.field_kind == KIND_TEXT_LEN || dst_data.field_kind == KIND_TEXT_CHAR))
    else $error("last flag on a byte that is not text");

  // An ignored byte never carries an error or an item index.
  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_data.field_kind == KIND_IGNORED) |->
      (!dst_data.overrun_error && dst_data.item_index == 8'd0))
    else $error("ignored byte carries error or index");

  // A tag byte restarts the descriptor with no overrun pending.
  a_tag_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && hold.start_flag) |=> (!state.overrun_seen && state.current_item == 8'd0))
    else $error("tag byte did not clear the descriptor state");
`endif

endmodule

`default_nettype wire

FILE: dv/eedp_checker.sv
// Scoreboard for the extended event descriptor parser: predicts every result and compares it.
`timescale 1ns / 1ps

module eedp_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  input  logic           src_ready,
  input  eedp_pkg::in_t  src_data,
  input  logic           dst_valid,
  input  logic           dst_ready,
  input  eedp_pkg::out_t dst_data,
  output int             errors,
  output int             pending
);
  import eedp_pkg::*;

  // Shadow copy of the parser state.
  logic [PHASE_W-1:0] ph;
  logic [7:0]         field_left;
  logic [7:0]         area_left;
  logic [7:0]         item_no;
  logic               overrun;

  out_t expected_fields[$];
  out_t want;

  function void finish_item();
    item_no = item_no + 8'd1;
    ph = (area_left == 8'd0) ? PH_TEXT_LEN : PH_DESC_LEN;
  endfunction

  // The items area ran out part way through an item: drop the rest and go to the text.
  function void cut_item();
    overrun = 1'b1;
    ph = PH_TEXT_LEN;
  endfunction

  function automatic out_t parse_byte(in_t req);
    out_t r;
    logic [7:0] b;
    b = req.data_byte;
    r = '0;
    r.field_byte = b;
    r.field_kind = KIND_IGNORED;
    if (req.start_flag) begin
      r.field_kind = KIND_TAG;
      ph = PH_LENGTH;
      field_left = 8'd0;
      area_left = 8'd0;
      item_no = 8'd0;
      overrun = 1'b0;
    end else begin
      case (ph)
        PH_LENGTH: begin
          r.field_kind = KIND_LENGTH;
          ph = PH_NUMBERS;
        end
        PH_NUMBERS: begin
          r.field_kind = KIND_NUMBERS;
          r.number_high = b[7:4];
          r.number_low = b[3:0];
          field_left = LANG_BYTES;
          ph = PH_LANG;
        end
        PH_LANG: begin
          r.field_kind = KIND_LANGUAGE;
          field_left = field_left - 8'd1;
          if (field_left == 8'd0) ph = PH_ITEMS_LEN;
        end
        PH_ITEMS_LEN: begin
          r.field_kind = KIND_ITEMS_LEN;
          area_left = b;
          ph = (b == 8'd0) ? PH_TEXT_LEN : PH_DESC_LEN;
        end
        PH_DESC_LEN: begin
          r.field_kind = KIND_DESC_LEN;
          r.item_index = item_no;
          area_left = area_left - 8'd1;
          field_left = b;
          if (area_left == 8'd0) cut_item();
          else ph = (b == 8'd0) ? PH_ITEM_LEN : PH_DESC_CHAR;
        end
        PH_DESC_CHAR: begin
          r.field_kind = KIND_DESC_CHAR;
          r.item_index = item_no;
          area_left = area_left - 8'd1;
          field_left = field_left - 8'd1;
          if (area_left == 8'd0) cut_item();
          else if (field_left == 8'd0) ph = PH_ITEM_LEN;
        end
        PH_ITEM_LEN: begin
          r.field_kind = KIND_ITEM_LEN;
          r.item_index = item_no;
          area_left = area_left - 8'd1;
          field_left = b;
          // An empty item text completes the item even on the last byte of the area.
          if (b == 8'd0) finish_item();
          else if (area_left == 8'd0) cut_item();
          else ph = PH_ITEM_CHAR;
        end
        PH_ITEM_CHAR: begin
          r.field_kind = KIND_ITEM_CHAR;
          r.item_index = item_no;
          area_left = area_left - 8'd1;
          field_left = field_left - 8'd1;
          if (field_left == 8'd0) finish_item();
          else if (area_left == 8'd0) cut_item();
        end
        PH_TEXT_LEN: begin
          r.field_kind = KIND_TEXT_LEN;
          field_left = b;
          if (b == 8'd0) begin
            r.last_of_descriptor = 1'b1;
            ph = PH_IDLE;
          end else begin
            ph = PH_TEXT_CHAR;
          end
        end
        PH_TEXT_CHAR: begin
          r.field_kind = KIND_TEXT_CHAR;
          field_left = field_left - 8'd1;
          if (field_left == 8'd0) begin
            r.last_of_descriptor = 1'b1;
            ph = PH_IDLE;
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase
    end
    if (r.field_kind != KIND_IGNORED) r.overrun_error = overrun;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph = PH_IDLE;
      field_left = 8'd0;
      area_left = 8'd0;
      item_no = 8'd0;
      overrun = 1'b0;
      expected_fields.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (src_valid && src_ready)
        expected_fields.insert(expected_fields.size(), parse_byte(src_data));
      if (dst_valid && dst_ready) begin
        if (expected_fields.size() == 0) begin
          $error("result with no request outstanding: kind %0d, byte %0h",
                 dst_data.field_kind, dst_data.field_byte);
          errors++;
        end else begin
          want = expected_fields.pop_front();
          check_field("field_kind", 8'(want.field_kind), 8'(dst_data.field_kind));
          check_field("field_byte", want.field_byte, dst_data.field_byte);
          check_field("number_high", 8'(want.number_high), 8'(dst_data.number_high));
          check_field("number_low", 8'(want.number_low), 8'(dst_data.number_low));
          check_field("item_index", want.item_index, dst_data.item_index);
          check_field("last_of_descriptor", 8'(want.last_of_descriptor),
                      8'(dst_data.last_of_descriptor));
          check_field("overrun_error", 8'(want.overrun_error), 8'(dst_data.overrun_error));
        end
      end
      pending = expected_fields.size();
    end
  end

endmodule

FILE: dv/tb.sv
// Testbench top for the extended event descriptor parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import eedp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  in_t  src_data = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  out_t dst_data;

  int errors;
  int pending;
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int target;

  logic [7:0] stream[$];

  always #5 clk = ~clk;

  extended_event_descriptor_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

  eedp_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(negedge clk) begin
    dst_ready <= !rst && ($urandom_range(0, 99) >= dst_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] value, input logic is_tag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data <= {value, is_tag};
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream.size(); i++) send_byte(stream[i], i == 0);
  endtask

  function automatic void stream_add(input logic [7:0] value);
    stream.insert(stream.size(), value);
  endfunction

  // Builds a descriptor with random content, mostly well formed.
  task automatic random_descriptor();
    logic [7:0] area[$];
    int n_items;
    int len;
    int area_len;
    int text_len;
    int pick;
    bit big;
    big = ($urandom_range(0, 49) == 0);
    n_items = big ? $urandom_range(20, 60) : $urandom_range(0, 3);
    for (int i = 0; i < n_items; i++) begin
      len = $urandom_range(0, 4);
      area.insert(area.size(), 8'(len));
      repeat (len) area.insert(area.size(), 8'($urandom_range(0, 255)));
      len = $urandom_range(0, 4);
      area.insert(area.size(), 8'(len));
      repeat (len) area.insert(area.size(), 8'($urandom_range(0, 255)));
    end
    while (area.size() > 255) void'(area.pop_back());
    area_len = area.size();
    pick = $urandom_range(0, 99);
    // A short items length cuts the area, usually part way through an item.
    if (area_len > 0 && pick < 20) begin
      area_len = $urandom_range(1, area_len);
      while (area.size() > area_len) void'(area.pop_back());
    end else if (pick >= 92) begin
      area_len = area_len + $urandom_range(1, 3);
      if (area_len > 255) area_len = 255;
    end
    text_len = big ? $urandom_range(100, 255) : $urandom_range(0, 6);
    stream.delete();
    repeat (6) stream_add(8'($urandom_range(0, 255)));
    stream_add(8'(area_len));
    foreach (area[i]) stream_add(area[i]);
    stream_add(8'(text_len));
    repeat (text_len) stream_add(8'($urandom_range(0, 255)));
    // Now and then the next tag arrives before this descriptor is over.
    if ($urandom_range(0, 99) < 8) begin
      len = $urandom_range(1, stream.size() - 1);
      while (stream.size() > len) void'(stream.pop_back());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bytes while idle are ignored.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Item length crosses the end of the items area; empty text.
    stream = '{8'h4E, 8'hFF, 8'hF0, 8'h00, 8'hFF, 8'h55, 8'h03, 8'h01, 8'hAA, 8'h05, 8'h00};
    send_stream();
    // Abandoned by a new tag where the language code should begin.
    stream = '{8'h4E, 8'h00, 8'h0F};
    send_stream();
    // Complete item, then a description length on the last area byte.
    stream = '{8'hFF, 8'h10, 8'h5A, 8'h6A, 8'h70, 8'h6E, 8'h04, 8'h00, 8'h01, 8'h63,
               8'h07, 8'h01, 8'h00};
    send_stream();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 84; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 84; end
        default: begin src_idle_pct = 29; dst_stall_pct = 29; end
      endcase
      target = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 99) < 15)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        random_descriptor();
        send_stream();
      end
      // Hold off until every outstanding result has come back.
      src_valid <= 1'b0;
      while (pending != 0) @(posedge clk);
      @(negedge clk);
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
